// ----- rtl/core/sfla_pkg.sv -----
// Shared constants, codes and types of the slot free-list allocator.
package sfla_pkg;

  // Number of record slots, and the widths that follow from it.
  localparam int Slots  = 32;
  localparam int SlotW  = 5;
  localparam int ExtW   = 6;
  localparam int MaxList = 32;

  // Command codes carried in the request.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_LIST  = 2'd2;

  // Status codes carried in each result.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // One entry of the slot store: link to the next free slot and the free mark.
  typedef struct packed {
    logic             link_vld;
    logic [SlotW-1:0] link;
    logic             free_mark;
  } slot_entry_t;

  localparam int EntryW = $bits(slot_entry_t);

endpackage

// ----- rtl/core/sfla_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
module sfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  // Write port and registered read port; read data holds while not read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/slot_free_list_allocator.sv -----
// Top level of the slot free-list allocator.
//
// One command is taken per request on the in_ channel: allocate, free or
// list free slots. Results leave on the out_ channel, tlast marking the final
// result of each command. Free slots form a LIFO chain whose links live in a
// single slot store RAM with a registered read port.
// Allocate from the never-used region and refusals decided from the extent
// produce their result in the cycle after acceptance. Allocate from the chain
// and free need one read-modify-write of the slot store: the read is issued
// on acceptance, the S_ALLOC or S_FREE state writes back and loads the
// result, then the next command can be taken. List walks the chain one
// store read per cycle while results are taken; at most 32 are emitted.
// Unused command code 3 is accepted and gives no result.
// Reset empties the chain and the used extent; the store itself needs no
// clearing since only written entries are ever read.
// A stalled receiver holds the result in the output register; the walk
// pauses and no new command is taken until that result has been taken.
module slot_free_list_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [1:0] op, [6:2] slot_index, [7] zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] slot_out, [6:5] status, [7] zero
  output logic       out_tlast
);

  import sfla_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;
  localparam logic [1:0] S_LIST  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [SlotW-1:0] head_r, head_nxt;
  logic             head_vld_r, head_vld_nxt;
  logic [ExtW-1:0]  extent_r, extent_nxt;
  logic [SlotW-1:0] cur_r, cur_nxt;
  logic [SlotW-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SlotW-1:0] out_slot_r, out_slot_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             accept;
  logic [1:0]       req_op;
  logic [SlotW-1:0] req_idx;
  logic             wr_en, rd_en;
  logic [SlotW-1:0] wr_addr, rd_addr;
  slot_entry_t      wr_entry, rd_entry;
  logic [EntryW-1:0] rd_bits;
  logic             list_final;

  // Slot store: link and free mark of each slot.
  sfla_ram #(
    .Width (EntryW),
    .Depth (Slots)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign rd_entry = slot_entry_t'(rd_bits);

  // Request decode and handshake.
  assign req_op    = in_tdata[1:0];
  assign req_idx   = in_tdata[6:2];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign list_final = !rd_entry.link_vld || (cnt_r == SlotW'(MaxList - 1));

  // Command sequencer: decisions, store accesses and result loading.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    head_vld_nxt   = head_vld_r;
    extent_nxt     = extent_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = extent_r[SlotW-1:0];
    wr_entry       = '0;
    rd_en          = 1'b0;
    rd_addr        = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_op)
            OP_ALLOC: begin
              if (head_vld_r) begin
                // Pop the chain head: its link is needed first.
                rd_en     = 1'b1;
                rd_addr   = head_r;
                cur_nxt   = head_r;
                state_nxt = S_ALLOC;
              end else if (extent_r < ExtW'(Slots)) begin
                // Take the next never-used slot.
                wr_en          = 1'b1;
                wr_addr        = extent_r[SlotW-1:0];
                wr_entry       = '0;
                extent_nxt     = extent_r + 1'b1;
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = extent_r[SlotW-1:0];
                out_status_nxt = ST_DONE;
                out_last_nxt   = 1'b1;
              end else begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_status_nxt = ST_FULL;
                out_last_nxt   = 1'b1;
              end
            end
            OP_FREE: begin
              if ({1'b0, req_idx} >= extent_r) begin
                // Never-used slot: refused without a store access.
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = req_idx;
                out_status_nxt = ST_NOT_LIVE;
                out_last_nxt   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = req_idx;
                cur_nxt   = req_idx;
                state_nxt = S_FREE;
              end
            end
            OP_LIST: begin
              if (head_vld_r) begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                cur_nxt   = head_r;
                cnt_nxt   = '0;
                state_nxt = S_LIST;
              end else begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = '0;
                out_status_nxt = ST_EMPTY;
                out_last_nxt   = 1'b1;
              end
            end
            default: begin
              // Unused code: taken and dropped.
            end
          endcase
        end
      end

      S_ALLOC: begin
        // The output register is empty here: the request was only taken
        // when it was free.
        head_nxt       = rd_entry.link;
        head_vld_nxt   = rd_entry.link_vld;
        wr_en          = 1'b1;
        wr_addr        = cur_r;
        wr_entry       = '0;
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = cur_r;
        out_status_nxt = ST_DONE;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_FREE: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = cur_r;
        out_last_nxt  = 1'b1;
        if (rd_entry.free_mark) begin
          out_status_nxt = ST_NOT_LIVE;
        end else begin
          // Push the slot onto the chain.
          wr_en              = 1'b1;
          wr_addr            = cur_r;
          wr_entry.link_vld  = head_vld_r;
          wr_entry.link      = head_r;
          wr_entry.free_mark = 1'b1;
          head_nxt           = cur_r;
          head_vld_nxt       = 1'b1;
          out_status_nxt     = ST_DONE;
        end
        state_nxt = S_IDLE;
      end

      S_LIST: begin
        // One chain entry per cycle while the output register can take it.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = cur_r;
          out_status_nxt = ST_DONE;
          out_last_nxt   = list_final;
          if (list_final) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_entry.link;
            cur_nxt = rd_entry.link;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_vld_r  <= 1'b0;
      extent_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_vld_r  <= head_vld_nxt;
      extent_r    <= extent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_status_r, out_slot_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/sfla_checker.sv -----
// Port-level checker of the slot free-list allocator, bound to the top level.
module sfla_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  import sfla_pkg::*;

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Full, refusal and empty results are single and final.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[6:5] != ST_DONE) |-> out_tlast)
    else $error("error result not marked last");

  // A full report carries slot zero, as does an empty list report.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[6:5] == ST_FULL) || (out_tdata[6:5] == ST_EMPTY))
      |-> out_tdata[4:0] == '0)
    else $error("full or empty report with non-zero slot");

  // No result straight after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A request is not taken while a result waits stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while result stalled");

endmodule

bind slot_free_list_allocator sfla_checker u_sfla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
